[rtl/bsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

  localparam int IMAGE_WIDTH  = 320;
  localparam int IMAGE_HEIGHT = 240;

  localparam int ADDR_W = 17;
  localparam int VAL_W  = 16;
  localparam int ST_W   = 3;

  localparam int HDR_LEN = 54;

  localparam int USED24   = IMAGE_WIDTH * 3;
  localparam int USED32   = IMAGE_WIDTH * 4;
  localparam int STRIDE24 = ((USED24 + 3) / 4) * 4;
  localparam int STRIDE32 = USED32;

  localparam int POS_W = $clog2(STRIDE32);
  localparam int COL_W = $clog2(IMAGE_WIDTH + 1);
  localparam int ROW_W = $clog2(IMAGE_HEIGHT + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_SIG    = 3'd1;
  localparam logic [ST_W-1:0] ST_SIZE   = 3'd2;
  localparam logic [ST_W-1:0] ST_FORMAT = 3'd3;
  localparam logic [ST_W-1:0] ST_OFFSET = 3'd4;
  localparam logic [ST_W-1:0] ST_TRUNC  = 3'd5;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // one byte's worth of work: optional pixel write, then optional status
  typedef struct packed {
    logic              has_pix;
    logic [ADDR_W-1:0] pix_addr;
    logic [VAL_W-1:0]  pix_val;
    logic              has_st;
    logic [ST_W-1:0]   st;
  } bsr_op_t;

endpackage

`default_nettype wire

[rtl/bsr_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [7:0]      in_tdata,
  input  wire logic            in_tuser,
  input  wire logic            in_tlast,
  input  wire logic            q_full,
  output logic                 q_push,
  output bsr_pkg::bsr_op_t     q_op
);
  import bsr_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_SKIP, PH_PIXELS} phase_t;

  localparam logic [31:0] HGT_POS = 32'(IMAGE_HEIGHT);
  localparam logic [31:0] HGT_NEG = 32'(0) - 32'(IMAGE_HEIGHT);
  localparam logic [ADDR_W-1:0] BASE_BOTTOM = ADDR_W'((IMAGE_HEIGHT - 1) * IMAGE_WIDTH);
  localparam logic [ADDR_W-1:0] W_STEP = ADDR_W'(IMAGE_WIDTH);

  phase_t            phase_r, phase_nxt, phase_eff;
  logic [31:0]       cnt_r, cnt_nxt, cnt_eff;
  logic [31:0]       off_r, off_nxt, off_eff;
  logic [31:0]       wid_r, wid_nxt, wid_eff;
  logic [31:0]       hgt_r, hgt_nxt, hgt_eff;
  logic [15:0]       bpp_r, bpp_nxt, bpp_eff;
  logic [31:0]       cmp_r, cmp_nxt, cmp_eff;
  logic              sig_bad_r, sig_bad_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [7:0]        blue_r, blue_nxt;
  logic [7:0]        green_r, green_nxt;

  logic        accept;
  logic        finished;
  logic [1:0]  sel;
  logic        bpp32;
  logic [1:0]  last_ch;
  logic        pos_in_used;
  logic        pos_last;
  bsr_op_t     op;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign sel       = cnt_eff[1:0] - 2'd2;
  assign bpp32     = (bpp_r == 16'd32);
  assign last_ch   = bpp32 ? 2'd3 : 2'd2;
  assign pos_in_used = bpp32 ? (32'(pos_r) < 32'(USED32)) : (32'(pos_r) < 32'(USED24));
  assign pos_last  = bpp32 ? (32'(pos_r) == 32'(STRIDE32 - 1))
                           : (32'(pos_r) == 32'(STRIDE24 - 1));

  always_comb begin
    phase_eff = in_tuser ? PH_HEADER : phase_r;
    cnt_eff   = in_tuser ? 32'd0 : cnt_r;
    off_eff   = in_tuser ? 32'd0 : off_r;
    wid_eff   = in_tuser ? 32'd0 : wid_r;
    hgt_eff   = in_tuser ? 32'd0 : hgt_r;
    bpp_eff   = in_tuser ? 16'd0 : bpp_r;
    cmp_eff   = in_tuser ? 32'd0 : cmp_r;

    phase_nxt   = phase_eff;
    cnt_nxt     = cnt_eff;
    off_nxt     = off_eff;
    wid_nxt     = wid_eff;
    hgt_nxt     = hgt_eff;
    bpp_nxt     = bpp_eff;
    cmp_nxt     = cmp_eff;
    sig_bad_nxt = in_tuser ? 1'b0 : sig_bad_r;
    pos_nxt     = in_tuser ? '0 : pos_r;
    ch_nxt      = in_tuser ? 2'd0 : ch_r;
    col_nxt     = in_tuser ? '0 : col_r;
    row_nxt     = in_tuser ? '0 : row_r;
    base_nxt    = base_r;
    blue_nxt    = blue_r;
    green_nxt   = green_r;
    finished    = 1'b0;
    op          = '0;

    unique case (phase_eff)
      PH_IDLE: begin
      end
      PH_HEADER: begin
        if (cnt_eff == 32'd0 && in_tdata != 8'h42) sig_bad_nxt = 1'b1;
        if (cnt_eff == 32'd1 && in_tdata != 8'h4D) sig_bad_nxt = 1'b1;
        if (cnt_eff >= 32'd10 && cnt_eff <= 32'd13) off_nxt[8*sel +: 8] = in_tdata;
        if (cnt_eff >= 32'd18 && cnt_eff <= 32'd21) wid_nxt[8*sel +: 8] = in_tdata;
        if (cnt_eff >= 32'd22 && cnt_eff <= 32'd25) hgt_nxt[8*sel +: 8] = in_tdata;
        if (cnt_eff >= 32'd28 && cnt_eff <= 32'd29) bpp_nxt[8*cnt_eff[0] +: 8] = in_tdata;
        if (cnt_eff >= 32'd30 && cnt_eff <= 32'd33) cmp_nxt[8*sel +: 8] = in_tdata;
        cnt_nxt = cnt_eff + 32'd1;
        if (cnt_eff == 32'(HDR_LEN - 1)) begin
          priority if (sig_bad_nxt) begin
            op.has_st = 1'b1;
            op.st     = ST_SIG;
          end else if (wid_nxt != 32'(IMAGE_WIDTH) ||
                       (hgt_nxt != HGT_POS && hgt_nxt != HGT_NEG)) begin
            op.has_st = 1'b1;
            op.st     = ST_SIZE;
          end else if (cmp_nxt != 32'd0 || (bpp_nxt != 16'd24 && bpp_nxt != 16'd32)) begin
            op.has_st = 1'b1;
            op.st     = ST_FORMAT;
          end else if (off_nxt < 32'(HDR_LEN)) begin
            op.has_st = 1'b1;
            op.st     = ST_OFFSET;
          end else begin
            op.has_st = 1'b0;
          end
          finished  = op.has_st;
          base_nxt  = hgt_nxt[31] ? '0 : BASE_BOTTOM;
          phase_nxt = (off_nxt == 32'(HDR_LEN)) ? PH_PIXELS : PH_SKIP;
        end
      end
      PH_SKIP: begin
        cnt_nxt = cnt_eff + 32'd1;
        if (cnt_nxt >= off_eff) phase_nxt = PH_PIXELS;
      end
      PH_PIXELS: begin
        if (pos_in_used) begin
          if (ch_r == 2'd0) blue_nxt = in_tdata;
          if (ch_r == 2'd1) green_nxt = in_tdata;
          if (ch_r == 2'd2) begin
            op.has_pix  = 1'b1;
            op.pix_addr = base_r + ADDR_W'(col_r);
            op.pix_val  = {in_tdata[7:3], green_r[7:2], blue_r[7:3]};
          end
          if (ch_r == last_ch) begin
            ch_nxt  = 2'd0;
            col_nxt = col_r + COL_W'(1);
          end else begin
            ch_nxt = ch_r + 2'd1;
          end
        end
        if (pos_last) begin
          pos_nxt = '0;
          ch_nxt  = 2'd0;
          col_nxt = '0;
          if (32'(row_r) == 32'(IMAGE_HEIGHT - 1)) begin
            op.has_st = 1'b1;
            op.st     = ST_OK;
            finished  = 1'b1;
          end else begin
            row_nxt  = row_r + ROW_W'(1);
            base_nxt = hgt_r[31] ? base_r + W_STEP : base_r - W_STEP;
          end
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      default: begin
      end
    endcase

    if (phase_eff != PH_IDLE) begin
      if (finished) begin
        phase_nxt = PH_IDLE;
      end else if (in_tlast) begin
        op.has_st = 1'b1;
        op.st     = ST_TRUNC;
        phase_nxt = PH_IDLE;
      end
    end
  end

  assign q_push = accept && (op.has_pix || op.has_st);
  assign q_op   = op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= '0;
      off_r     <= '0;
      wid_r     <= '0;
      hgt_r     <= '0;
      bpp_r     <= '0;
      cmp_r     <= '0;
      sig_bad_r <= 1'b0;
      pos_r     <= '0;
      ch_r      <= 2'd0;
      col_r     <= '0;
      row_r     <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      off_r     <= off_nxt;
      wid_r     <= wid_nxt;
      hgt_r     <= hgt_nxt;
      bpp_r     <= bpp_nxt;
      cmp_r     <= cmp_nxt;
      sig_bad_r <= sig_bad_nxt;
      pos_r     <= pos_nxt;
      ch_r      <= ch_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base_r  <= base_nxt;
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/bsr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsr_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire bsr_pkg::bsr_op_t push_op,
  input  wire logic             pop,
  output bsr_pkg::bsr_op_t      pop_op,
  output logic                  full,
  output logic                  empty
);
  import bsr_pkg::*;

  bsr_op_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

[rtl/bsr_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsr_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bsr_pkg::bsr_op_t q_op,
  input  wire logic             q_empty,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [39:0]           out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);
  import bsr_pkg::*;

  logic    cur_valid_r;
  bsr_op_t cur_r;
  logic    xfer;
  logic    two_left;
  logic    need;

  assign xfer     = cur_valid_r && out_tready;
  assign two_left = cur_r.has_pix && cur_r.has_st;
  assign need     = !cur_valid_r || (xfer && !two_left);
  assign q_pop    = need && !q_empty;

  assign out_tvalid = cur_valid_r;
  assign out_tuser  = cur_r.has_pix ? KIND_PIXEL : KIND_STATUS;
  assign out_tlast  = !two_left;
  assign out_tdata  = cur_r.has_pix
                    ? {4'd0, ST_OK, cur_r.pix_val, cur_r.pix_addr}
                    : {4'd0, cur_r.st, VAL_W'(0), ADDR_W'(0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (need) begin
      cur_valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_op;
    end else if (xfer && two_left) begin
      cur_r.has_pix <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/bmp_stream_to_rgb565_unit.sv]
// Path: each byte's results pass through the op queue and then the output register.
// Throughput: one byte per cycle while the op queue is not full; a byte giving two
// results holds the output for both, and a 4-entry op queue between parser and
// output absorbs it. Output rate is one result per cycle while out_tready is high
// and the queue is not empty, set by the single output register.
// Reset: synchronous, active-low rst_n idles the parser and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module bmp_stream_to_rgb565_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // first_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [16:0] pixel_address, [32:17] pixel_value,
                                       // [35:33] status, [39:36] zero
  output logic             out_tuser,  // kind
  output logic             out_tlast   // run_end
);
  import bsr_pkg::*;

  bsr_op_t push_op, pop_op;
  logic    push, pop, full, empty;

  bsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_op      (push_op)
  );

  bsr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .full    (full),
    .empty   (empty)
  );

  bsr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_op       (pop_op),
    .q_empty    (empty),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[dv/bsr_checker.sv]
`timescale 1ns / 1ps

module bsr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          due_count
);
  import bsr_pkg::*;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_SKIP, PH_PIXELS} parse_phase_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  val;
    logic [ST_W-1:0]   st;
    logic              run_end;
  } bmp_result_t;

  parse_phase_t phase = PH_IDLE;
  logic [31:0]  hdr_idx, pix_off, img_w, img_h, compr;
  logic [15:0]  bpp, row, pos;
  logic [7:0]   blue_b, green_b;
  logic         top_first, sig_bad;
  bmp_result_t  results_due[$];
  int           fails = 0;

  task automatic clear_parse();
    hdr_idx   = '0;
    pix_off   = '0;
    img_w     = '0;
    img_h     = '0;
    compr     = '0;
    bpp       = '0;
    row       = '0;
    pos       = '0;
    blue_b    = '0;
    green_b   = '0;
    top_first = 1'b0;
    sig_bad   = 1'b0;
  endtask

  function automatic logic [ST_W-1:0] header_status();
    logic [31:0] mag;
    mag = img_h[31] ? (32'd0 - img_h) : img_h;
    if (sig_bad) return ST_SIG;
    if (img_w != IMAGE_WIDTH || mag != IMAGE_HEIGHT) return ST_SIZE;
    if (compr != 0 || (bpp != 16'd24 && bpp != 16'd32)) return ST_FORMAT;
    if (pix_off < HDR_LEN) return ST_OFFSET;
    return ST_OK;
  endfunction

  // work out the results one accepted byte causes
  task automatic parse_byte(input logic [7:0] b, input logic first, input logic last);
    bmp_result_t     res [2];
    int              n;
    logic            done;
    logic [ST_W-1:0] st;
    logic [31:0]     bypp, used, stride, y, addr;
    n    = 0;
    done = 1'b0;
    if (first) begin
      clear_parse();
      phase = PH_HEADER;
    end
    if (phase == PH_IDLE) return;
    case (phase)
      PH_HEADER: begin
        if (hdr_idx == 0 && b != SIG_B) sig_bad = 1'b1;
        if (hdr_idx == 1 && b != SIG_M) sig_bad = 1'b1;
        if (hdr_idx >= 10 && hdr_idx <= 13) pix_off |= 32'(b) << (8 * (hdr_idx - 10));
        if (hdr_idx >= 18 && hdr_idx <= 21) img_w |= 32'(b) << (8 * (hdr_idx - 18));
        if (hdr_idx >= 22 && hdr_idx <= 25) img_h |= 32'(b) << (8 * (hdr_idx - 22));
        if (hdr_idx >= 28 && hdr_idx <= 29) bpp |= 16'(b) << (8 * (hdr_idx - 28));
        if (hdr_idx >= 30 && hdr_idx <= 33) compr |= 32'(b) << (8 * (hdr_idx - 30));
        hdr_idx = hdr_idx + 1;
        if (hdr_idx == HDR_LEN) begin
          st = header_status();
          if (st != ST_OK) begin
            res[n] = '{KIND_STATUS, '0, '0, st, 1'b0};
            n++;
            done = 1'b1;
          end else begin
            top_first = img_h[31];
            if (pix_off == HDR_LEN) phase = PH_PIXELS;
            else phase = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        hdr_idx = hdr_idx + 1;
        if (hdr_idx >= pix_off) phase = PH_PIXELS;
      end
      default: begin
        bypp   = (bpp == 16'd32) ? 32'd4 : 32'd3;
        used   = IMAGE_WIDTH * bypp;
        stride = (used + 3) & ~32'd3;
        if (pos < used) begin
          case (pos % bypp)
            0: blue_b = b;
            1: green_b = b;
            2: begin
              y    = top_first ? 32'(row) : (IMAGE_HEIGHT - 1 - 32'(row));
              addr = y * IMAGE_WIDTH + pos / bypp;
              res[n] = '{KIND_PIXEL, addr[ADDR_W-1:0], {b[7:3], green_b[7:2], blue_b[7:3]},
                         ST_OK, 1'b0};
              n++;
            end
            default: ;
          endcase
        end
        pos = pos + 1;
        if (pos >= stride) begin
          pos = '0;
          if (32'(row) + 1 >= IMAGE_HEIGHT) begin
            res[n] = '{KIND_STATUS, '0, '0, ST_OK, 1'b0};
            n++;
            done = 1'b1;
          end else begin
            row = row + 1;
          end
        end
      end
    endcase
    if (done) begin
      phase = PH_IDLE;
    end else if (last) begin
      res[n] = '{KIND_STATUS, '0, '0, ST_TRUNC, 1'b0};
      n++;
      phase = PH_IDLE;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) res[i].run_end = 1'b1;
      results_due.push_back(res[i]);
    end
  endtask

  task automatic check_result();
    bmp_result_t got, want;
    got = '{out_tuser, out_tdata[ADDR_W-1:0], out_tdata[ADDR_W+VAL_W-1:ADDR_W],
            out_tdata[ADDR_W+VAL_W+ST_W-1:ADDR_W+VAL_W], out_tlast};
    if (results_due.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected result: kind=%0d addr=%0d val=%h status=%0d run_end=%0b",
                 got.kind, got.addr, got.val, got.st, got.run_end);
    end else begin
      want = results_due.pop_front();
      if (got != want) begin
        fails++;
        if (fails <= 10)
          $display({"result mismatch: exp kind=%0d addr=%0d val=%h status=%0d run_end=%0b",
                    " | got kind=%0d addr=%0d val=%h status=%0d run_end=%0b"},
                   want.kind, want.addr, want.val, want.st, want.run_end,
                   got.kind, got.addr, got.val, got.st, got.run_end);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase = PH_IDLE;
      clear_parse();
      results_due.delete();
    end else begin
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
    fail_count <= fails;
    due_count  <= results_due.size();
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import bsr_pkg::*;

  localparam int RUN_LIMIT = 1_000_000;
  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int          fail_count;
  int          due_count;
  int          cycle_cnt = 0;
  int          idle_pct = 35;
  int          sent_bytes = 0;
  bit          pressure_go = 1'b0;
  bit          pressure_done = 1'b0;
  logic [7:0]  hdr [54];
  logic [7:0]  pix_pat[$];

  bmp_stream_to_rgb565_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  bsr_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_bytes++;
  endtask

  // header from fields, then data; pix_pat overrides data from the pixel offset on
  task automatic send_file(input bit sig_ok, input logic [31:0] w, input logic [31:0] h,
                           input logic [15:0] bpp, input logic [31:0] comp,
                           input logic [31:0] off, input int total, input int last_at);
    logic [7:0] b;
    for (int k = 0; k < 54; k++) hdr[k] = 8'($urandom_range(0, 255));
    hdr[0] = SIG_B;
    hdr[1] = SIG_M;
    if (!sig_ok) begin
      if ($urandom_range(0, 1)) hdr[0] = SIG_B ^ 8'($urandom_range(1, 255));
      else hdr[1] = SIG_M ^ 8'($urandom_range(1, 255));
    end
    for (int k = 0; k < 4; k++) begin
      hdr[10+k] = off[8*k +: 8];
      hdr[18+k] = w[8*k +: 8];
      hdr[22+k] = h[8*k +: 8];
      hdr[30+k] = comp[8*k +: 8];
    end
    hdr[28] = bpp[7:0];
    hdr[29] = bpp[15:8];
    for (int i = 0; i < total; i++) begin
      if (i < 54) b = hdr[i];
      else if (i >= off && i - off < pix_pat.size()) b = pix_pat[i - off];
      else b = 8'($urandom_range(0, 255));
      send_byte(b, i == 0, i == last_at);
    end
    pix_pat.delete();
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : out_side
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (pressure_go && !pressure_done) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stim
    logic [31:0] w, h, comp, off;
    logic [15:0] bpp;
    bit          sig_ok;
    int          total, last_at, body, pick, err;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // idle bytes after reset
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b0);

    // 24 bpp bottom-up, channel extremes, data ends on a blue byte
    pix_pat = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h07, 8'h03, 8'h07,
                8'hF8, 8'hFC, 8'hF8, 8'h55};
    send_file(1'b1, IMAGE_WIDTH, IMAGE_HEIGHT, 16'd24, 0, 54, 54 + 13, 54 + 12);
    // 32 bpp top-down with gap before data, end on a red byte: pixel then truncation
    pix_pat = '{8'h12, 8'h34, 8'h56, 8'hFF, 8'hAB, 8'hCD, 8'hEF};
    send_file(1'b1, IMAGE_WIDTH, -IMAGE_HEIGHT, 16'd32, 0, 60, 60 + 7, 60 + 6);
    // bad signature reported ahead of every other fault
    send_file(1'b0, 321, 17, 16'd16, 1, 0, 60, -1);
    send_file(1'b1, 319, IMAGE_HEIGHT, 16'd24, 0, 54, 56, -1);
    send_file(1'b1, IMAGE_WIDTH, 241, 16'd24, 0, 54, 56, -1);
    send_file(1'b1, IMAGE_WIDTH, 32'h8000_0000, 16'd24, 0, 54, 56, -1);
    send_file(1'b1, IMAGE_WIDTH, IMAGE_HEIGHT, 16'd16, 0, 54, 56, -1);
    send_file(1'b1, IMAGE_WIDTH, IMAGE_HEIGHT, 16'd32, 3, 54, 56, -1);
    send_file(1'b1, IMAGE_WIDTH, IMAGE_HEIGHT, 16'd24, 0, 53, 56, -1);
    send_file(1'b1, IMAGE_WIDTH, -IMAGE_HEIGHT, 16'd32, 0, 0, 56, -1);
    // end of data on the last header byte, good and bad header
    send_file(1'b1, IMAGE_WIDTH, IMAGE_HEIGHT, 16'd24, 0, 54, 54, 53);
    send_file(1'b1, IMAGE_WIDTH, IMAGE_HEIGHT, 16'd8, 0, 54, 54, 53);
    // truncated inside header and inside the skip
    send_file(1'b1, IMAGE_WIDTH, IMAGE_HEIGHT, 16'd24, 0, 54, 21, 20);
    send_file(1'b1, IMAGE_WIDTH, -IMAGE_HEIGHT, 16'd24, 0, 100, 71, 70);
    // restarts mid-header and mid-pixels
    send_file(1'b1, IMAGE_WIDTH, IMAGE_HEIGHT, 16'd24, 0, 54, 30, -1);
    send_file(1'b1, IMAGE_WIDTH, IMAGE_HEIGHT, 16'd32, 0, 54, 54 + 40, -1);
    send_byte(SIG_B, 1'b1, 1'b1);
    // trailing bytes after the end are ignored
    send_file(1'b1, IMAGE_WIDTH, IMAGE_HEIGHT, 16'd24, 0, 54, 54 + 9, 54 + 5);

    // result side holds off while bytes keep coming
    idle_pct = 0;
    pressure_go = 1'b1;
    send_file(1'b1, IMAGE_WIDTH, -IMAGE_HEIGHT, 16'd24, 0, 54, 54 + 150, 54 + 149);

    while (sent_bytes < 1450) begin
      idle_pct = ($urandom_range(0, 4) == 0) ? 0 : 35;
      pick = $urandom_range(0, 99);
      sig_ok = 1'b1;
      w = IMAGE_WIDTH;
      h = $urandom_range(0, 1) ? IMAGE_HEIGHT : -IMAGE_HEIGHT;
      bpp = $urandom_range(0, 1) ? 16'd32 : 16'd24;
      comp = 0;
      if ($urandom_range(0, 19) == 0) off = $urandom_range(200, 600);
      else if ($urandom_range(0, 3) == 0) off = 54;
      else off = $urandom_range(55, 90);
      if (pick < 70) begin
        body = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(13, 90);
        total = off + body;
        err = $urandom_range(0, 9);
        if (err < 7) last_at = total - 1;
        else if (err < 9) last_at = -1;
        else last_at = $urandom_range(0, total - 1);
        send_file(sig_ok, w, h, bpp, comp, off, total, last_at);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 2)) begin
          err = $urandom_range(0, 5);
          case (err)
            0: sig_ok = 1'b0;
            1: w = $urandom_range(0, 1) ? $urandom : (IMAGE_WIDTH ^ (32'd1 << $urandom_range(0, 31)));
            2: begin
              if ($urandom_range(0, 2) == 0) h = 32'h8000_0000;
              else h = h ^ (32'd1 << $urandom_range(0, 30));
            end
            3: bpp = bpp ^ (16'd1 << $urandom_range(0, 15));
            4: comp = $urandom | 32'd1;
            default: off = $urandom_range(0, 53);
          endcase
        end
        total = 54 + $urandom_range(0, 6);
        last_at = $urandom_range(0, 1) ? total - 1 : -1;
        send_file(sig_ok, w, h, bpp, comp, off, total, last_at);
      end else if (pick < 95) begin
        total = 54 + $urandom_range(0, 4);
        last_at = $urandom_range(0, 1) ? total - 1 : $urandom_range(0, total - 1);
        send_file($urandom_range(0, 1), $urandom, $urandom, 16'($urandom), $urandom, $urandom,
                  total, last_at);
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[bmp_stream_to_rgb565_unit.f]
rtl/bsr_pkg.sv
rtl/bsr_front.sv
rtl/bsr_queue.sv
rtl/bsr_back.sv
rtl/bmp_stream_to_rgb565_unit.sv
dv/bsr_checker.sv
dv/tb_top.sv
